// ===== src/gzhp_pkg.sv =====
// Shared types, constants and helpers for the gzip header parser.
`default_nettype none

package gzhp_pkg;

   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int LENGTH_BITS        = 24;
   localparam int EXTRA_BITS         = 16;
   localparam int FLAG_BITS          = 5;

   localparam logic [7:0] MAGIC_ID1     = 8'h1f;
   localparam logic [7:0] MAGIC_ID2     = 8'h8b;
   localparam logic [7:0] METHOD_DEFL   = 8'h08;
   localparam logic [7:0] FLG_RESV      = 8'he0;
   localparam logic [4:0] FLG_HCRC      = 5'h02;
   localparam logic [4:0] FLG_EXTRA     = 5'h04;
   localparam logic [4:0] FLG_NAME      = 5'h08;
   localparam logic [4:0] FLG_COMMENT   = 5'h10;
   localparam int         FIXED_LAST_POS = 9;

   localparam logic [2:0] STAGE_EXTRA   = 3'd1;
   localparam logic [2:0] STAGE_NAME    = 3'd2;
   localparam logic [2:0] STAGE_COMMENT = 3'd3;
   localparam logic [2:0] STAGE_HCRC    = 3'd4;

   typedef enum logic [3:0] {
      PH_FIXED   = 4'd0,
      PH_XLEN0   = 4'd1,
      PH_XLEN1   = 4'd2,
      PH_XDATA   = 4'd3,
      PH_NAME    = 4'd4,
      PH_COMMENT = 4'd5,
      PH_HCRC0   = 4'd6,
      PH_HCRC1   = 4'd7,
      PH_DONE    = 4'd8
   } phase_type;

   function automatic phase_type next_part(input logic [4:0] flags, input logic [2:0] stage);
      phase_type ph;
      ph = PH_DONE;
      if (stage <= STAGE_EXTRA && (flags & FLG_EXTRA) != '0) begin
         ph = PH_XLEN0;
      end else if (stage <= STAGE_NAME && (flags & FLG_NAME) != '0) begin
         ph = PH_NAME;
      end else if (stage <= STAGE_COMMENT && (flags & FLG_COMMENT) != '0) begin
         ph = PH_COMMENT;
      end else if (stage <= STAGE_HCRC && (flags & FLG_HCRC) != '0) begin
         ph = PH_HCRC0;
      end
      return ph;
   endfunction

endpackage

`default_nettype wire

// ===== src/gzip_header_parser.sv =====
// Top level of the gzip member header parser: one buffer byte per beat.
// An accepted byte is held in the input register; its result is then registered in the result register.
// Throughput: one byte per cycle; the input stage stalls only while a result waits.
// The per-byte state update is a single pass of logic between the two registers.
// Reset: synchronous, active high; clears the parse state and empties both stages.
// The first byte after reset starts a new buffer.
`default_nettype none

module gzip_header_parser
   import gzhp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] data_byte
   input  wire logic                   req_tlast,   // last_byte
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [LENGTH_BITS-1:0]      rsp_tdata,   // [23:0] header_length
   output logic                        rsp_tuser    // [0] status
);

   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT =
      (COUNT_BITS >= LENGTH_BITS) ? COUNT_BITS'({LENGTH_BITS{1'b1}}) : {COUNT_BITS{1'b1}};

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [FLAG_BITS-1:0]  flags_ff, flags_in;
   logic [EXTRA_BITS-1:0] extra_ff, extra_in;
   logic [7:0]            xlow_ff, xlow_in;
   logic                  given_ff, given_in;

   logic                  out_valid_ff, out_valid_in;
   logic [LENGTH_BITS-1:0] out_len_ff, out_len_in;
   logic                  out_status_ff, out_status_in;

   logic                  process;
   logic                  give;
   logic                  ok;
   logic                  fail;
   logic [COUNT_BITS-1:0] pos;
   logic [COUNT_BITS-1:0] count_inc;
   logic [31:0]           count_wide;
   logic [EXTRA_BITS-1:0] extra_dec;
   logic [EXTRA_BITS-1:0] extra_new;

   assign process    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || process;
   assign in_valid_in = req_tvalid && req_tready ? 1'b1 : (process ? 1'b0 : in_valid_ff);

   assign pos        = count_ff;
   assign count_inc  = count_ff + COUNT_BITS'(1);
   assign count_wide = 32'(count_inc);
   assign extra_dec  = extra_ff - EXTRA_BITS'(1);
   assign extra_new  = {in_byte_ff, xlow_ff};

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      extra_in      = extra_ff;
      xlow_in       = xlow_ff;
      given_in      = given_ff;
      give          = 1'b0;
      ok            = 1'b0;
      fail          = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_len_in    = out_len_ff;
      out_status_in = out_status_ff;
      if (process) begin
         if (given_ff) begin
            give = 1'b0;
         end else if (count_ff >= COUNT_LIMIT) begin
            give = 1'b1;
         end else begin
            count_in = count_inc;
            case (phase_ff)
               PH_FIXED: begin
                  if (pos == '0 && in_byte_ff != MAGIC_ID1) begin
                     fail = 1'b1;
                  end
                  if (pos == COUNT_BITS'(1) && in_byte_ff != MAGIC_ID2) begin
                     fail = 1'b1;
                  end
                  if (pos == COUNT_BITS'(2) && in_byte_ff != METHOD_DEFL) begin
                     fail = 1'b1;
                  end
                  if (pos == COUNT_BITS'(3)) begin
                     if ((in_byte_ff & FLG_RESV) != '0) begin
                        fail = 1'b1;
                     end
                     flags_in = in_byte_ff[FLAG_BITS-1:0];
                  end
                  if (pos >= COUNT_BITS'(FIXED_LAST_POS)) begin
                     phase_in = next_part(flags_ff, STAGE_EXTRA);
                  end
               end
               PH_XLEN0: begin
                  xlow_in  = in_byte_ff;
                  phase_in = PH_XLEN1;
               end
               PH_XLEN1: begin
                  extra_in = extra_new;
                  phase_in = (extra_new == '0) ? next_part(flags_ff, STAGE_NAME) : PH_XDATA;
               end
               PH_XDATA: begin
                  extra_in = extra_dec;
                  if (extra_dec == '0) begin
                     phase_in = next_part(flags_ff, STAGE_NAME);
                  end
               end
               PH_NAME: begin
                  if (in_byte_ff == 8'h00) begin
                     phase_in = next_part(flags_ff, STAGE_COMMENT);
                  end
               end
               PH_COMMENT: begin
                  if (in_byte_ff == 8'h00) begin
                     phase_in = next_part(flags_ff, STAGE_HCRC);
                  end
               end
               PH_HCRC0: phase_in = PH_HCRC1;
               PH_HCRC1: phase_in = PH_DONE;
               default:  phase_in = PH_DONE;
            endcase
            if (fail) begin
               give = 1'b1;
            end else if (phase_in == PH_DONE) begin
               give = 1'b1;
               ok   = 1'b1;
            end else if (in_last_ff) begin
               give = 1'b1;
            end
         end
         if (give) begin
            out_valid_in  = 1'b1;
            out_status_in = !ok;
            out_len_in    = ok ? count_wide[LENGTH_BITS-1:0] : '0;
            given_in      = 1'b1;
         end
         if (in_last_ff) begin
            phase_in = PH_FIXED;
            count_in = '0;
            flags_in = '0;
            extra_in = '0;
            xlow_in  = '0;
            given_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_FIXED;
         count_ff     <= '0;
         flags_ff     <= '0;
         extra_ff     <= '0;
         xlow_ff      <= '0;
         given_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         extra_ff     <= extra_in;
         xlow_ff      <= xlow_in;
         given_ff     <= given_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      out_len_ff    <= out_len_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_len_ff;
   assign rsp_tuser  = out_status_ff;

   a_invalid_zero_len: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff |-> out_len_ff == '0)
      else $error("invalid result carries a nonzero length");

   a_valid_min_len: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_status_ff |-> out_len_ff >= LENGTH_BITS'(FIXED_LAST_POS + 1))
      else $error("valid header shorter than the fixed part");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      process && in_last_ff |=> count_ff == '0 && !given_ff && phase_ff == PH_FIXED)
      else $error("last byte did not rearm the parser");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("stalled input stage lost its byte");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      process && given_ff |-> !give)
      else $error("second result for one buffer");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for gzip_header_parser: directed and random buffers against a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gzhp_pkg::*;

   localparam int              TB_COUNT_BITS  = 16;
   localparam longint unsigned COUNT_LIMIT    =
      ((64'd1 << TB_COUNT_BITS) - 64'd1) > 64'hFFFFFF ? 64'hFFFFFF
                                                     : ((64'd1 << TB_COUNT_BITS) - 64'd1);
   localparam int              LONG_HOLD      = 400;
   localparam int              WATCHDOG_LIMIT = 5000;
   localparam int              TOTAL_BYTES    = 1900;
   localparam int              QUIET_BYTES    = 300;
   localparam logic [7:0]      FLG_TEXT_BYTE  = 8'h01;

   typedef struct packed {
      logic                   status;
      logic [LENGTH_BITS-1:0] hdr_len;
   } verdict_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tready = 1'b0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire [LENGTH_BITS-1:0]  rsp_tdata;
   wire                    rsp_tuser;

   phase_type              cur_phase    = PH_FIXED;
   int unsigned            consumed     = 0;
   logic [4:0]             hdr_flags    = '0;
   logic [15:0]            extra_left   = '0;
   logic [7:0]             extra_lo     = '0;
   bit                     verdict_sent = 1'b0;

   verdict_type            verdicts_due[$];
   logic [7:0]             frame[$];
   int                     errors       = 0;
   int                     sent_bytes   = 0;
   int                     idle_cycles  = 0;
   bit                     send_gaps    = 1'b1;
   bit                     recv_gaps    = 1'b1;
   bit                     hold_request = 1'b0;

   always #4 clock = ~clock;

   gzip_header_parser #(
      .COUNT_BITS(TB_COUNT_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic void clear_parse();
      cur_phase    = PH_FIXED;
      consumed     = 0;
      hdr_flags    = '0;
      extra_left   = '0;
      extra_lo     = '0;
      verdict_sent = 1'b0;
   endfunction

   function automatic phase_type part_after(input logic [2:0] stage);
      if (stage <= STAGE_EXTRA && (hdr_flags & FLG_EXTRA) != '0) return PH_XLEN0;
      if (stage <= STAGE_NAME && (hdr_flags & FLG_NAME) != '0) return PH_NAME;
      if (stage <= STAGE_COMMENT && (hdr_flags & FLG_COMMENT) != '0) return PH_COMMENT;
      if (stage <= STAGE_HCRC && (hdr_flags & FLG_HCRC) != '0) return PH_HCRC0;
      return PH_DONE;
   endfunction

   function automatic bit parse_step(input logic [7:0] b, input logic last,
                                     output verdict_type v);
      int unsigned pos;
      bit          emit;
      bit          ok;
      emit = 1'b0;
      ok   = 1'b0;
      v    = '0;
      if (verdict_sent) begin
         if (last) clear_parse();
         return 1'b0;
      end
      if (consumed >= COUNT_LIMIT) begin
         emit = 1'b1;
      end else begin
         pos      = consumed;
         consumed = consumed + 1;
         case (cur_phase)
            PH_FIXED: begin
               if ((pos == 0 && b != MAGIC_ID1) || (pos == 1 && b != MAGIC_ID2) ||
                   (pos == 2 && b != METHOD_DEFL) || (pos == 3 && (b & FLG_RESV) != '0)) begin
                  emit = 1'b1;
               end else begin
                  if (pos == 3) hdr_flags = b[4:0];
                  if (pos >= FIXED_LAST_POS) cur_phase = part_after(STAGE_EXTRA);
               end
            end
            PH_XLEN0: begin
               extra_lo  = b;
               cur_phase = PH_XLEN1;
            end
            PH_XLEN1: begin
               extra_left = {b, extra_lo};
               cur_phase  = (extra_left == '0) ? part_after(STAGE_NAME) : PH_XDATA;
            end
            PH_XDATA: begin
               extra_left = extra_left - 16'd1;
               if (extra_left == '0) cur_phase = part_after(STAGE_NAME);
            end
            PH_NAME: begin
               if (b == 8'h00) cur_phase = part_after(STAGE_COMMENT);
            end
            PH_COMMENT: begin
               if (b == 8'h00) cur_phase = part_after(STAGE_HCRC);
            end
            PH_HCRC0: begin
               cur_phase = PH_HCRC1;
            end
            default: begin
               cur_phase = PH_DONE;
            end
         endcase
         if (!emit && cur_phase == PH_DONE) begin
            emit = 1'b1;
            ok   = 1'b1;
         end else if (last) begin
            emit = 1'b1;
         end
      end
      if (emit) begin
         v.status  = !ok;
         v.hdr_len = ok ? consumed[LENGTH_BITS-1:0] : '0;
         if (last) clear_parse();
         else verdict_sent = 1'b1;
      end
      return emit;
   endfunction

   function automatic void add_header(input logic [7:0] flg_byte, input int xlen,
                                      input int name_len, input int note_len);
      frame.push_back(MAGIC_ID1);
      frame.push_back(MAGIC_ID2);
      frame.push_back(METHOD_DEFL);
      frame.push_back(flg_byte);
      repeat (6) frame.push_back(8'($urandom));
      if ((flg_byte[4:0] & FLG_EXTRA) != '0) begin
         frame.push_back(xlen[7:0]);
         frame.push_back(xlen[15:8]);
         repeat (xlen[15:0]) frame.push_back(8'($urandom));
      end
      if ((flg_byte[4:0] & FLG_NAME) != '0) begin
         repeat (name_len) frame.push_back(8'($urandom_range(1, 255)));
         frame.push_back(8'h00);
      end
      if ((flg_byte[4:0] & FLG_COMMENT) != '0) begin
         repeat (note_len) frame.push_back(8'($urandom_range(1, 255)));
         frame.push_back(8'h00);
      end
      if ((flg_byte[4:0] & FLG_HCRC) != '0) begin
         repeat (2) frame.push_back(8'($urandom));
      end
   endfunction

   function automatic void add_noise(input int n);
      repeat (n) frame.push_back(8'($urandom));
   endfunction

   function automatic void cut_frame(input int keep);
      while (frame.size() > keep) void'(frame.pop_back());
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      verdict_type v;
      if (send_gaps && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_bytes++;
      if (parse_step(b, last, v)) verdicts_due.push_back(v);
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
      frame.delete();
   endtask

   task automatic test_fixed_fields();
      add_header(8'h00, 0, 0, 0);
      cut_frame(1);
      send_frame();
      for (int k = 0; k < 3; k++) begin
         add_header(8'h00, 0, 0, 0);
         frame[k] = ~frame[k];
         send_frame();
      end
      for (int k = 5; k < 8; k++) begin
         add_header(8'(1 << k), 0, 0, 0);
         send_frame();
      end
      add_header(8'h00, 0, 0, 0);
      send_frame();
      add_header(FLG_TEXT_BYTE, 0, 0, 0);
      add_noise(2);
      send_frame();
      add_header(8'h00, 0, 0, 0);
      cut_frame(6);
      send_frame();
   endtask

   task automatic test_optional_parts();
      logic [7:0] single_flags[4];
      single_flags = '{{3'b000, FLG_EXTRA}, {3'b000, FLG_NAME},
                       {3'b000, FLG_COMMENT}, {3'b000, FLG_HCRC}};
      add_header(8'h1f, 0, 0, 0);
      send_frame();
      foreach (single_flags[i]) begin
         add_header(single_flags[i], 3, 3, 3);
         send_frame();
         add_header(single_flags[i], 3, 3, 3);
         void'(frame.pop_back());
         send_frame();
      end
      add_header({3'b000, FLG_EXTRA}, 5, 0, 0);
      cut_frame(11);
      send_frame();
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (48) begin
         add_noise($urandom_range(1, 3));
         send_frame();
      end
      req_tvalid <= 1'b0;
      while (hold_request) @(posedge clock);
   endtask

   task automatic test_random();
      int stop_at;
      int quiet_at;
      int xlen;
      stop_at  = TOTAL_BYTES;
      quiet_at = stop_at - QUIET_BYTES;
      while (sent_bytes < stop_at) begin
         if (sent_bytes >= quiet_at) begin
            send_gaps = 1'b0;
            recv_gaps = 1'b0;
         end
         xlen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 6);
         add_header(8'($urandom_range(0, 31)), xlen, $urandom_range(0, 8),
                    $urandom_range(0, 8));
         case ($urandom_range(0, 9))
            0: begin
               frame.delete();
               add_noise($urandom_range(1, 12));
            end
            1: begin
               cut_frame($urandom_range(1, frame.size()));
            end
            2: begin
               frame[$urandom_range(0, 2)] = frame[0] ^ 8'($urandom_range(1, 255));
            end
            3: begin
               frame[3] = frame[3] | {3'($urandom_range(1, 7)), 5'b00000};
            end
            default: begin
               add_noise($urandom_range(0, 3));
            end
         endcase
         send_frame();
      end
   endtask

   initial begin
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: result without pending header, status %0d length %0d",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            exp_v = verdicts_due.pop_front();
            if (rsp_tuser !== exp_v.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_v.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== exp_v.hdr_len) begin
               $display("%0t: header length expected %0d actual %0d",
                        $time, exp_v.hdr_len, rsp_tdata);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("gzip_header_parser verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_fixed_fields();
      test_optional_parts();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("gzip_header_parser verification clean");
      end else begin
         $display("gzip_header_parser verification failed");
      end
      $finish;
   end

endmodule

// ===== gzip_header_parser.f =====
src/gzhp_pkg.sv
src/gzip_header_parser.sv
tb/tb_top.sv
